>>> hw/rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Types and constants shared by the double-ended stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

	localparam int unsigned FIELD_W = 25;
	localparam int unsigned SUM_W   = 27;  // low + high + padded size never wraps
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned STAT_W  = 2;

	localparam logic [SUM_W-1:0] HDR_BYTES  = SUM_W'(16);
	localparam logic [SUM_W-1:0] ALIGN_MASK = SUM_W'(15);

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC_LOW  = 3'd0,
		MODE_ALLOC_HIGH = 3'd1,
		MODE_ALLOC_TEMP = 3'd2,
		MODE_FREE_LOW   = 3'd3,
		MODE_FREE_HIGH  = 3'd4,
		MODE_READ_LOW   = 3'd5,
		MODE_READ_HIGH  = 3'd6
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_BAD_MARK = 2'd2
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FIELD_W-1:0] req_bytes;
		logic [FIELD_W-1:0] mark_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] payload_offset;
		logic [FIELD_W-1:0] mark_out;
	} rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsa_req_if.sv
// ----------------------------------------------------------------------------
// dsa_req_if
// Request channel: valid/ready plus mode, request size and mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [24:0] req_bytes;
	logic [24:0] mark_in;

	modport source (output valid, output mode, output req_bytes, output mark_in,
		input ready);
	modport sink (input valid, input mode, input req_bytes, input mark_in,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dsa_rsp_if.sv
// ----------------------------------------------------------------------------
// dsa_rsp_if
// Result channel: valid/ready plus status, payload offset and mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [24:0] payload_offset;
	logic [24:0] mark_out;

	modport source (output valid, output status, output payload_offset,
		output mark_out, input ready);
	modport sink (input valid, input status, input payload_offset,
		input mark_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/double_ended_stack_allocator_top.sv
// ----------------------------------------------------------------------------
// double_ended_stack_allocator_top
// Bump allocator working a region from both ends, with marks and one temp.
// ----------------------------------------------------------------------------
// One request per cycle is sustained while rsp.ready stays high. A request
// lands in the input register, is evaluated against the state registers in
// one pass of adds and compares, and its result is loaded into the result
// register. The state registers update as the request leaves the input
// register, so the next request sees them at once. Backpressure on the
// result side stalls the input register, and through it req.ready. The
// user must write total_size only while the block is idle (not enforced).
`default_nettype none

module double_ended_stack_allocator_top
	import dsa_pkg::*;
#(
	parameter int unsigned REGION_ADDR_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [24:0] cfg_wdata,
	dsa_req_if.sink          req,
	dsa_rsp_if.source        rsp
);

	req_t in_data, item_s1;
	rsp_t result, result_s2;
	logic valid_s1, valid_s2, can_load, fire;

	assign in_data = '{mode: req.mode, req_bytes: req.req_bytes, mark_in: req.mark_in};
	assign fire    = valid_s1 && can_load;

	dsa_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_data  (in_data),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dsa_core #(
		.REGION_ADDR_BITS (REGION_ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.result    (result)
	);

	dsa_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.can_load  (can_load),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2),
		.out_ready (rsp.ready)
	);

	assign rsp.valid          = valid_s2;
	assign rsp.status         = result_s2.status;
	assign rsp.payload_offset = result_s2.payload_offset;
	assign rsp.mark_out       = result_s2.mark_out;

endmodule

`default_nettype wire

>>> hw/rtl/dsa_in_stage.sv
// ----------------------------------------------------------------------------
// dsa_in_stage
// Input register: holds one request beat until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_in_stage
	import dsa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire req_t  in_data,
	input  wire logic  take,
	output logic       valid_s1,
	output req_t       item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/dsa_core.sv
// ----------------------------------------------------------------------------
// dsa_core
// Allocator state and the single-pass request evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_core
	import dsa_pkg::*;
#(
	parameter int unsigned REGION_ADDR_BITS = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [FIELD_W-1:0]  cfg_wdata,
	input  wire logic                fire,
	input  wire req_t                item,
	output rsp_t                     result
);

	localparam logic [33:0] RegionMax = 34'd1 << REGION_ADDR_BITS;

	logic [FIELD_W-1:0] total_q, low_used_q, high_used_q, temp_mark_q;
	logic               temp_live_q;

	logic [FIELD_W-1:0] low_d, high_d, temp_mark_d, cfg_sat;
	logic               temp_live_d;
	logic [SUM_W-1:0]   size, h_rel_w, new_h, total_w, low_w, off_hi;
	logic [FIELD_W-1:0] h_rel;
	logic               fit_lo, fit_hi;

	assign cfg_sat = ({9'd0, cfg_wdata} > RegionMax) ? RegionMax[FIELD_W-1:0] : cfg_wdata;

	always_comb begin
		size    = (({2'b00, item.req_bytes} + ALIGN_MASK) & ~ALIGN_MASK) + HDR_BYTES;
		// high side after dropping a live temporary
		h_rel   = (temp_live_q && temp_mark_q <= high_used_q) ? temp_mark_q : high_used_q;
		total_w = {2'b00, total_q};
		low_w   = {2'b00, low_used_q};
		h_rel_w = {2'b00, h_rel};
		fit_lo  = (low_w + {2'b00, high_used_q} + size) <= total_w;
		fit_hi  = (low_w + h_rel_w + size) <= total_w;
		new_h   = h_rel_w + size;
		off_hi  = total_w - new_h + HDR_BYTES;

		low_d       = low_used_q;
		high_d      = high_used_q;
		temp_live_d = temp_live_q;
		temp_mark_d = temp_mark_q;
		result      = '0;

		case (item.mode)
			MODE_ALLOC_LOW: begin
				if (fit_lo) begin
					result.payload_offset = low_used_q + FIELD_W'(16);
					low_d = low_w[FIELD_W-1:0] + size[FIELD_W-1:0];
				end else begin
					result.status = STAT_NO_SPACE;
				end
			end
			MODE_ALLOC_HIGH, MODE_ALLOC_TEMP: begin
				high_d      = h_rel;
				temp_live_d = (item.mode == MODE_ALLOC_TEMP);
				if (item.mode == MODE_ALLOC_TEMP) begin
					temp_mark_d = h_rel;
				end
				if (fit_hi) begin
					high_d = new_h[FIELD_W-1:0];
					result.payload_offset = off_hi[FIELD_W-1:0];
				end else begin
					result.status = STAT_NO_SPACE;
				end
			end
			MODE_FREE_LOW: begin
				if (item.mark_in > low_used_q) begin
					result.status = STAT_BAD_MARK;
				end else begin
					low_d = item.mark_in;
				end
			end
			MODE_FREE_HIGH: begin
				temp_live_d = 1'b0;
				if (item.mark_in > h_rel) begin
					result.status = STAT_BAD_MARK;
					high_d = h_rel;
				end else begin
					high_d = item.mark_in;
				end
			end
			MODE_READ_LOW: begin
				result.mark_out = low_used_q;
			end
			MODE_READ_HIGH: begin
				temp_live_d = 1'b0;
				high_d = h_rel;
				result.mark_out = h_rel;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			low_used_q  <= '0;
			high_used_q <= '0;
			temp_live_q <= 1'b0;
			temp_mark_q <= '0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_sat;
			end
			if (fire) begin
				low_used_q  <= low_d;
				high_used_q <= high_d;
				temp_live_q <= temp_live_d;
				temp_mark_q <= temp_mark_d;
			end
		end
	end

	a_nospace_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && result.status == STAT_NO_SPACE) |-> (result.payload_offset == '0))
		else $error("failed allocation returned a nonzero offset");

	a_low_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == MODE_ALLOC_LOW && result.status == STAT_OK)
		|=> (low_used_q > $past(low_used_q)))
		else $error("low side did not grow on a good allocation");

	a_low_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == MODE_ALLOC_LOW && result.status != STAT_OK)
		|=> (low_used_q == $past(low_used_q) && high_used_q == $past(high_used_q)))
		else $error("failed low allocation changed the state");

	a_temp_set: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == MODE_ALLOC_TEMP) |=> temp_live_q)
		else $error("temporary allocation not marked live");

endmodule

`default_nettype wire

>>> hw/rtl/dsa_out_stage.sv
// ----------------------------------------------------------------------------
// dsa_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_out_stage
	import dsa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire rsp_t  result,
	output logic       can_load,
	output logic       valid_s2,
	output rsp_t       result_s2,
	input  wire logic  out_ready
);

	assign can_load = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed requests into the double-ended stack allocator
// through its valid/ready channels, predicts every result beat from a
// shadow copy of the allocator state, and checks each beat field by field.
// ----------------------------------------------------------------------------

module testbench;
	import dsa_pkg::*;

	localparam int unsigned REGION_BITS = 24;
	localparam logic [24:0] REGION_LIMIT = 25'(1) << REGION_BITS;
	localparam logic [26:0] HDR = 27'd16;
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int unsigned LONG_HOLD = 90;

	typedef struct packed {
		logic [24:0] total;
		logic [24:0] lo_used;
		logic [24:0] hi_used;
		logic        tmp_live;
		logic [24:0] tmp_mark;
	} alloc_state_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [24:0] cfg_wdata;

	dsa_req_if req_ch();
	dsa_rsp_if rsp_ch();

	double_ended_stack_allocator_top #(
		.REGION_ADDR_BITS(REGION_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #10 clk = ~clk;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	alloc_state_t model_state = '0;
	alloc_state_t plan_state = '0;

	int unsigned n_queued = 0;
	int unsigned n_sent = 0;
	int unsigned n_done = 0;
	int unsigned backlog = 0;
	int unsigned mismatches = 0;
	int unsigned n_sizes = 0;
	int unsigned cnt_ok = 0, cnt_full = 0, cnt_bad = 0;
	int unsigned in_stalls = 0;
	int unsigned src_style = 0, snk_style = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	bit req_fire = 1'b0, rsp_fire = 1'b0;

	// ------------------------------------------------------------------
	// Allocator prediction
	// ------------------------------------------------------------------
	function automatic logic [26:0] padded(input logic [24:0] req);
		return HDR + ((27'(req) + 27'd15) & ~27'd15);
	endfunction

	function automatic bit fits(input alloc_state_t s, input logic [26:0] size);
		return 27'(s.lo_used) + 27'(s.hi_used) + size <= 27'(s.total);
	endfunction

	function automatic void drop_temp(inout alloc_state_t s);
		if (s.tmp_live) begin
			s.tmp_live = 1'b0;
			if (s.tmp_mark <= s.hi_used)
				s.hi_used = s.tmp_mark;
		end
	endfunction

	function automatic void grab_high(inout alloc_state_t s, input logic [24:0] req,
		inout rsp_t r);
		logic [26:0] size;
		size = padded(req);
		drop_temp(s);
		if (!fits(s, size)) begin
			r.status = STAT_NO_SPACE;
		end else begin
			s.hi_used = 25'(27'(s.hi_used) + size);
			r.status = STAT_OK;
			r.payload_offset = 25'(27'(s.total) - 27'(s.hi_used) + HDR);
		end
	endfunction

	function automatic rsp_t alloc_step(inout alloc_state_t s, input req_t q);
		rsp_t r;
		logic [26:0] size;
		r = '0;
		case (q.mode)
			MODE_ALLOC_LOW: begin
				size = padded(q.req_bytes);
				if (!fits(s, size)) begin
					r.status = STAT_NO_SPACE;
				end else begin
					r.payload_offset = 25'(27'(s.lo_used) + HDR);
					s.lo_used = 25'(27'(s.lo_used) + size);
				end
			end
			MODE_ALLOC_HIGH: grab_high(s, q.req_bytes, r);
			MODE_ALLOC_TEMP: begin
				drop_temp(s);
				s.tmp_mark = s.hi_used;
				grab_high(s, q.req_bytes, r);
				// temp stays armed even on failure; its mark equals hi_used then
				s.tmp_live = 1'b1;
			end
			MODE_FREE_LOW: begin
				if (q.mark_in > s.lo_used)
					r.status = STAT_BAD_MARK;
				else
					s.lo_used = q.mark_in;
			end
			MODE_FREE_HIGH: begin
				drop_temp(s);
				if (q.mark_in > s.hi_used)
					r.status = STAT_BAD_MARK;
				else
					s.hi_used = q.mark_in;
			end
			MODE_READ_LOW: r.mark_out = s.lo_used;
			MODE_READ_HIGH: begin
				drop_temp(s);
				r.mark_out = s.hi_used;
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic req_t pack_req(input logic [2:0] m, input logic [24:0] b,
		input logic [24:0] k);
		req_t q;
		q.mode = m;
		q.req_bytes = b;
		q.mark_in = k;
		return q;
	endfunction

	// Mostly well-formed: sizes that fit, marks at or below the used amount;
	// the rest exact fits, one-past fits, bad marks and raw random values.
	function automatic req_t random_req(input alloc_state_t g);
		req_t q;
		int unsigned pick, room, used, hi_eff;
		q.req_bytes = 25'($urandom);
		q.mark_in = 25'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 24)
			q.mode = MODE_ALLOC_LOW;
		else if (pick < 44)
			q.mode = MODE_ALLOC_HIGH;
		else if (pick < 58)
			q.mode = MODE_ALLOC_TEMP;
		else if (pick < 70)
			q.mode = MODE_FREE_LOW;
		else if (pick < 82)
			q.mode = MODE_FREE_HIGH;
		else if (pick < 90)
			q.mode = MODE_READ_LOW;
		else if (pick < 98)
			q.mode = MODE_READ_HIGH;
		else
			q.mode = MODE_UNUSED;

		hi_eff = (g.tmp_live && g.tmp_mark <= g.hi_used) ? g.tmp_mark : g.hi_used;
		used = g.lo_used + ((q.mode == MODE_ALLOC_LOW) ? g.hi_used : hi_eff);
		room = (g.total > used) ? g.total - used : 0;
		pick = $urandom_range(0, 9);
		if (q.mode <= MODE_ALLOC_TEMP) begin
			if (pick < 7)
				q.req_bytes = 25'($urandom_range(0, room / 4 + 40));
			else if (pick == 7)
				q.req_bytes = (room >= 16) ? 25'(room - 16) : '0;
			else if (pick == 8)
				q.req_bytes = (room >= 15) ? 25'(room - 15) : '0;
		end else if (q.mode == MODE_FREE_LOW || q.mode == MODE_FREE_HIGH) begin
			used = (q.mode == MODE_FREE_LOW) ? g.lo_used : hi_eff;
			if (pick < 6)
				q.mark_in = 25'($urandom_range(0, used));
			else if (pick == 6)
				q.mark_in = 25'(used);
			else if (pick == 7)
				q.mark_in = 25'(used + 1);
			else if (pick == 8)
				q.mark_in = '0;
		end
		return q;
	endfunction

	function automatic int unsigned draw_gap(input int unsigned style);
		case (style)
			0: return 0;
			1: return $urandom_range(0, 17);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		endcase
	endfunction

	// keeps the planning copy of the state in step with what is queued
	task automatic queue_req(input req_t q);
		void'(alloc_step(plan_state, q));
		pending_reqs.push_back(q);
		n_queued++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (n_done < n_queued);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_region(input logic [24:0] v);
		logic [24:0] sat;
		sat = (v > REGION_LIMIT) ? REGION_LIMIT : v;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		model_state.total = sat;
		plan_state.total = sat;
		n_sizes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic note_mismatch(input string what, input logic [24:0] want,
		input logic [24:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at result %0d: expected %0h, got %0h",
				what, n_done, want, got);
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------
	always @(negedge clk) begin : req_driver
		req_t cur;
		bit busy;
		int unsigned wait_left;
		if (arst_n) begin
			if (busy && req_fire) begin
				busy = 1'b0;
				wait_left = draw_gap(src_style);
			end else if (wait_left != 0) begin
				wait_left--;
			end
			if (!busy && wait_left == 0 && pending_reqs.size() != 0) begin
				cur = pending_reqs.pop_front();
				busy = 1'b1;
				n_sent++;
			end
			backlog = pending_reqs.size();
			req_ch.valid <= busy;
			if (busy) begin
				req_ch.mode <= cur.mode;
				req_ch.req_bytes <= cur.req_bytes;
				req_ch.mark_in <= cur.mark_in;
			end else begin
				req_ch.mode <= 3'($urandom);
				req_ch.req_bytes <= 25'($urandom);
				req_ch.mark_in <= 25'($urandom);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result-side ready
	// ------------------------------------------------------------------
	always @(negedge clk) begin : rsp_ready_driver
		int unsigned wait_left;
		if (arst_n) begin
			if (rsp_fire)
				wait_left = draw_gap(snk_style);
			else if (wait_left != 0)
				wait_left--;
			rsp_ch.ready <= (wait_left == 0) && (hold_left == 0);
		end
	end

	// one long result stall while requests keep coming, to back up the input
	always @(posedge clk) begin : hold_counter
		if (hold_left != 0) begin
			hold_left--;
		end else if (!hold_done && n_sent >= 400 && backlog > 20) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each request beat, check each result beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		rsp_t got, want;
		req_t taken;
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		rsp_fire = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (arst_n && req_ch.valid && !req_ch.ready)
			in_stalls++;

		if (rsp_fire) begin
			got.status = rsp_ch.status;
			got.payload_offset = rsp_ch.payload_offset;
			got.mark_out = rsp_ch.mark_out;
			if (expected_rsps.size() == 0) begin
				note_mismatch("unexpected beat offset", '0, got.payload_offset);
			end else begin
				want = expected_rsps.pop_front();
				if (got.status !== want.status)
					note_mismatch("status", 25'(want.status), 25'(got.status));
				if (got.payload_offset !== want.payload_offset)
					note_mismatch("payload_offset", want.payload_offset, got.payload_offset);
				if (got.mark_out !== want.mark_out)
					note_mismatch("mark_out", want.mark_out, got.mark_out);
			end
			n_done++;
		end

		if (req_fire) begin
			taken.mode = req_ch.mode;
			taken.req_bytes = req_ch.req_bytes;
			taken.mark_in = req_ch.mark_in;
			want = alloc_step(model_state, taken);
			expected_rsps.push_back(want);
			case (want.status)
				STAT_OK: cnt_ok++;
				STAT_NO_SPACE: cnt_full++;
				default: cnt_bad++;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : sequencer
		int unsigned n_items;
		logic [24:0] region;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = '0;
		req_ch.req_bytes = '0;
		req_ch.mark_in = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// region size still at its reset value of zero
		@(posedge clk);
		queue_req(pack_req(MODE_ALLOC_LOW, '0, '0));
		queue_req(pack_req(MODE_ALLOC_TEMP, 25'd5, '0));
		queue_req(pack_req(MODE_UNUSED, '1, '1));
		wait_idle();

		// oversized write saturates to the full region
		set_region('1);
		@(posedge clk);
		queue_req(pack_req(MODE_ALLOC_LOW, '0, '0));
		queue_req(pack_req(MODE_ALLOC_LOW, 25'd1, '0));
		queue_req(pack_req(MODE_ALLOC_HIGH, 25'd17, '0));
		queue_req(pack_req(MODE_ALLOC_TEMP, 25'd100, '0));
		queue_req(pack_req(MODE_ALLOC_TEMP, 25'd33, '0));
		queue_req(pack_req(MODE_READ_HIGH, '0, '0));
		queue_req(pack_req(MODE_FREE_HIGH, '0, 25'd1000000));
		queue_req(pack_req(MODE_FREE_LOW, '0, '1));
		queue_req(pack_req(MODE_FREE_LOW, '0, 25'd16));
		queue_req(pack_req(MODE_ALLOC_LOW, '1, '0));
		queue_req(pack_req(MODE_FREE_LOW, '0, '0));
		queue_req(pack_req(MODE_FREE_HIGH, '0, '0));
		// exact fit of the whole region, then both sides full
		queue_req(pack_req(MODE_ALLOC_LOW, REGION_LIMIT - 25'd16, '0));
		queue_req(pack_req(MODE_ALLOC_HIGH, '0, '0));
		queue_req(pack_req(MODE_ALLOC_TEMP, '0, '0));
		queue_req(pack_req(MODE_FREE_LOW, '0, '0));
		queue_req(pack_req(MODE_ALLOC_HIGH, REGION_LIMIT - 25'd16, '0));
		queue_req(pack_req(MODE_FREE_HIGH, '0, '0));
		queue_req(pack_req(MODE_ALLOC_TEMP, '0, '0));
		queue_req(pack_req(MODE_FREE_HIGH, '0, '0));
		queue_req(pack_req(MODE_ALLOC_LOW, 25'd8000, '0));
		wait_idle();

		// shrink below what the low side already holds
		set_region(25'd4096);
		@(posedge clk);
		queue_req(pack_req(MODE_ALLOC_LOW, '0, '0));
		queue_req(pack_req(MODE_ALLOC_HIGH, '0, '0));
		queue_req(pack_req(MODE_FREE_LOW, '0, '0));
		queue_req(pack_req(MODE_ALLOC_LOW, '0, '0));

		for (int ph = 0; ph < 7; ph++) begin
			wait_idle();
			src_style = ph % 3;
			snk_style = (ph / 2) % 3;
			case (ph)
				0: begin region = REGION_LIMIT; n_items = 110; end
				1: begin region = 25'($urandom_range(256, 4096)); n_items = 110; end
				2: begin region = '0; n_items = 30; end
				3: begin region = 25'($urandom_range(0, REGION_LIMIT)); n_items = 110; end
				4: begin region = '1; n_items = 100; end
				5: begin region = 25'($urandom_range(16, 600)); n_items = 120; end
				default: begin region = REGION_LIMIT + 25'd1; n_items = 100; end
			endcase
			set_region(region);
			@(posedge clk);
			repeat (n_items) queue_req(random_req(plan_state));
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (expected_rsps.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_rsps.size());
		end
		$display("checked %0d results over %0d region sizes: %0d ok, %0d out of space, %0d bad mark",
			n_done, n_sizes, cnt_ok, cnt_full, cnt_bad);
		$display("request input held off for %0d cycles; long result stall %s",
			in_stalls, hold_done ? "applied" : "not reached");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("timeout with %0d of %0d results received", n_done, n_queued);
		$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_req_if.sv
hw/rtl/dsa_rsp_if.sv
hw/rtl/dsa_in_stage.sv
hw/rtl/dsa_core.sv
hw/rtl/dsa_out_stage.sv
hw/rtl/double_ended_stack_allocator_top.sv
tb/testbench.sv
